@@ hdl/mfpte_pkg.sv @@
package mfpte_pkg;

    // Port count and pattern length
    localparam int NUM_PORTS    = 16;
    localparam int PATTERN_BITS = 32;

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int POS_W  = $clog2(PATTERN_BITS + 1);
    localparam int PIDX_W = $clog2(PATTERN_BITS);

    // Word modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_SETUP = 1'b1;

    // Port function codes
    localparam logic [2:0] FN_NONE = 3'd0;
    localparam logic [2:0] FN_DIN  = 3'd1;
    localparam logic [2:0] FN_AIN  = 3'd2;
    localparam logic [2:0] FN_PMO  = 3'd3;
    localparam logic [2:0] FN_PWM  = 3'd4;

    // Flag bit positions
    localparam int FL_ANY_BIT  = 0;
    localparam int FL_NEG_BIT  = 1;
    localparam int FL_ONCE_BIT = 2;

    // Pin drive codes
    localparam logic [1:0] DRV_LEAVE = 2'd0;
    localparam logic [1:0] DRV_HIGH  = 2'd1;
    localparam logic [1:0] DRV_LOW   = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [3:0]  port_index;
        logic        pin_level;
        logic        sweep_start;
        logic        adc_done;
        logic [9:0]  adc_value;
        logic [2:0]  func_code;
        logic [2:0]  func_flags;
        logic [15:0] out_divider;
        logic [31:0] pattern_word;
        logic [3:0]  adc_channel;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  pin_drive;
        logic        adc_start;
        logic [3:0]  adc_select;
        logic [31:0] edge_count;
        logic [31:0] frequency;
        logic [31:0] idle_ticks;
        logic [9:0]  analog_value;
    } out_word_t;

    // One port's entry in the state memory
    typedef struct packed {
        logic [2:0]              port_function;
        logic [2:0]              port_flags;
        logic [15:0]             bit_divider;
        logic [15:0]             divider_count;
        logic [POS_W-1:0]        bit_position;
        logic [PATTERN_BITS-1:0] out_pattern;
        logic [31:0]             edges_seen;
        logic [31:0]             period_ticks;
        logic [31:0]             period_average;
        logic [31:0]             quiet_ticks;
        logic                    previous_level;
        logic [3:0]              sample_channel;
    } port_entry_t;

endpackage

@@ hdl/multi_function_port_tick_engine_top.sv @@
// Port tick engine: each input word either configures one port (setup) or
// services one port for one timer tick, and every word returns exactly one
// result word. A word's port entry is first read from the single-port state
// memory (a registered read), then updated, written back and, once no result
// waits, the result register loaded. One word is in work at a time;
// a finished result waits in the output register while the next word is
// taken. Ports are valid after reset with no clearing pass: a never-written
// entry reads as all zero. Converted samples live in a small register file
// because they are written for the converter owner, not the served port.
module multi_function_port_tick_engine_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mfpte_pkg::in_word_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mfpte_pkg::out_word_t out_data
);
    import mfpte_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                state_reg;
    in_word_t              item_reg;
    port_entry_t           rd_data_reg;
    port_entry_t           mem [NUM_PORTS];
    logic [NUM_PORTS-1:0]  valid_reg;
    logic [9:0]            sample_reg [NUM_PORTS];
    logic                  busy_reg;
    logic [PORT_W-1:0]     owner_reg;
    logic                  out_valid_reg;
    out_word_t             out_data_reg;

    logic                  in_fire;
    logic                  exec_go;
    logic [PORT_W-1:0]     addr;
    logic                  idx_ok;
    port_entry_t           cur;
    port_entry_t           ent_next;
    logic                  chk_fire;
    logic                  busy_next;
    logic [PORT_W-1:0]     owner_next;
    out_word_t             out_next;
    logic                  wr_en;
    logic [16:0]           count_inc;
    logic [POS_W-1:0]      pos;
    logic [32:0]           avg_sum;
    logic                  rise;
    logic                  fall;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign addr   = PORT_W'(item_reg.port_index);
    assign idx_ok = ({28'd0, item_reg.port_index} < 32'(NUM_PORTS));

    // Entry as seen by this word: unwritten entries read as reset value
    assign cur = valid_reg[addr] ? rd_data_reg : '0;

    // Update one port entry and build the result
    always_comb
    begin
        ent_next   = cur;
        busy_next  = busy_reg;
        owner_next = owner_reg;
        out_next   = '0;
        wr_en      = 1'b0;
        chk_fire   = 1'b0;
        count_inc  = {1'b0, cur.divider_count} + 17'd1;
        pos        = cur.bit_position;
        avg_sum    = '0;
        rise       = item_reg.pin_level && !cur.previous_level;
        fall       = !item_reg.pin_level && cur.previous_level;

        if (item_reg.mode == MODE_SETUP)
        begin
            if (idx_ok)
            begin
                wr_en                   = 1'b1;
                ent_next.port_function  = item_reg.func_code;
                ent_next.port_flags     = item_reg.func_flags;
                ent_next.bit_divider    = item_reg.out_divider;
                ent_next.out_pattern    = PATTERN_BITS'(item_reg.pattern_word);
                ent_next.sample_channel = item_reg.adc_channel;
                ent_next.bit_position   = POS_W'(PATTERN_BITS);
                ent_next.divider_count  = '0;
                ent_next.edges_seen     = '0;
                ent_next.period_ticks   = '0;
                ent_next.period_average = '0;
                ent_next.quiet_ticks    = '0;
            end
        end
        else
        begin
            // Store a finished conversion first, releasing the converter
            if (item_reg.sweep_start && busy_reg && item_reg.adc_done)
            begin
                chk_fire  = 1'b1;
                busy_next = 1'b0;
            end
            if (idx_ok)
            begin
                wr_en = 1'b1;
                unique case (cur.port_function) inside
                    FN_DIN:
                    begin
                        ent_next.period_ticks = cur.period_ticks + 32'd1;
                        if (rise)
                        begin
                            if (cur.port_flags[FL_ANY_BIT] || !cur.port_flags[FL_NEG_BIT])
                                ent_next.edges_seen = cur.edges_seen + 32'd1;
                            ent_next.quiet_ticks = '0;
                        end
                        else if (fall)
                        begin
                            if (cur.port_flags[FL_ANY_BIT] || cur.port_flags[FL_NEG_BIT])
                                ent_next.edges_seen = cur.edges_seen + 32'd1;
                            avg_sum = {1'b0, cur.period_average}
                                    + {1'b0, ent_next.period_ticks};
                            ent_next.period_average = avg_sum[32:1];
                            ent_next.period_ticks   = '0;
                            ent_next.quiet_ticks    = '0;
                        end
                        else
                        begin
                            ent_next.quiet_ticks = cur.quiet_ticks + 32'd1;
                        end
                    end
                    FN_AIN:
                    begin
                        if (!busy_next)
                        begin
                            busy_next           = 1'b1;
                            owner_next          = addr;
                            out_next.adc_start  = 1'b1;
                            out_next.adc_select = cur.sample_channel;
                        end
                    end
                    FN_PMO, FN_PWM:
                    begin
                        if (count_inc >= {1'b0, cur.bit_divider})
                        begin
                            ent_next.divider_count = '0;
                            if (pos == '0 || pos > POS_W'(PATTERN_BITS))
                            begin
                                pos = POS_W'(PATTERN_BITS);
                                if (cur.port_flags[FL_ONCE_BIT])
                                    ent_next.out_pattern =
                                        cur.port_flags[FL_NEG_BIT] ? '1 : '0;
                            end
                            pos = pos - POS_W'(1);
                            ent_next.bit_position = pos;
                            out_next.pin_drive =
                                ent_next.out_pattern[pos[PIDX_W-1:0]] ? DRV_HIGH : DRV_LOW;
                        end
                        else
                        begin
                            ent_next.divider_count = count_inc[15:0];
                        end
                    end
                    default:
                    begin
                        ent_next = cur;
                    end
                endcase
                ent_next.previous_level = item_reg.pin_level;
            end
        end

        // Report the served port's counters after the update
        if (idx_ok)
        begin
            out_next.edge_count   = ent_next.edges_seen;
            out_next.frequency    = ent_next.period_average;
            out_next.idle_ticks   = ent_next.quiet_ticks;
            out_next.analog_value = (chk_fire && owner_reg == addr) ?
                                    item_reg.adc_value : sample_reg[addr];
        end
    end

    // State memory: synchronous read, write back on execute
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_data_reg <= mem[PORT_W'(in_data.port_index)];
        if (exec_go && wr_en)
            mem[addr] <= ent_next;
    end

    // Sequence control, converter state, samples and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            busy_reg      <= 1'b0;
            owner_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
                sample_reg[i] <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !exec_go)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (exec_go)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        busy_reg      <= busy_next;
                        owner_reg     <= owner_next;
                        if (wr_en)
                            valid_reg[addr] <= 1'b1;
                        if (chk_fire)
                            sample_reg[owner_reg] <= item_reg.adc_value;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold the word and its result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
            item_reg <= in_data;
        if (exec_go)
            out_data_reg <= out_next;
    end

    // One word in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("word accepted while another is in work");

    // A result appears only after an execute step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_EXEC))
        else $error("result raised without an execute step");

    // No converter channel without a start request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.adc_start) |-> (out_data.adc_select == '0))
        else $error("channel selected without a start request");

    // A started conversion leaves the converter busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.adc_start && $rose(out_valid)) |-> busy_reg)
        else $error("converter start without ownership");

endmodule
